// ===== rtl/wpf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpf_pkg: shared types and constants of the waypoint follower
// Action codes, configuration indexes, reset values and the control record
// that the sequencer sends to the iterative root/divide unit.
// ----------------------------------------------------------------------------
package wpf_pkg;

    localparam int unsigned MAX_WAYPOINTS_DEF = 64;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned RADIUS_W = 24;
    localparam int unsigned SPEED_W  = 10;
    localparam int unsigned DT_W     = 16;
    localparam int unsigned CFG_IW   = 2;
    localparam int unsigned CFG_DW   = 24;

    localparam int unsigned MAG_W    = COORD_W + 1;     // axis difference magnitude
    localparam int unsigned PROD_W   = 2 * MAG_W;       // multiplier product
    localparam int unsigned DIST_W   = PROD_W;          // sum of three squares
    localparam int unsigned ROOT_W   = 34;
    localparam int unsigned STEP_W   = 18;
    localparam int unsigned NUM_W    = MAG_W + STEP_W;  // dividend of a step
    localparam int unsigned WP_W     = 3 * COORD_W + RADIUS_W;

    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 10'd150;
    localparam logic [SPEED_W-1:0]  SPEED_CAP    = 10'd1000;
    localparam logic [RADIUS_W-1:0] ACCEPT_RESET = 24'd12800;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_DEST  = 3'd1,
        ACT_TICK  = 3'd2,
        ACT_PAUSE = 3'd3,
        ACT_PLACE = 3'd4
    } t_action;

    typedef enum logic [CFG_IW-1:0] {
        CFG_SPEED  = 2'd0,
        CFG_ACCEPT = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic start;
        logic root;     // 1: square root, 0: divide
    } t_iter_ctl;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SD_RD,
        ST_SD_DIST,
        ST_SD_EVAL,
        ST_SD_FIN,
        ST_TK_DIST,
        ST_TK_ACC,
        ST_TK_CMP,
        ST_TK_NRD,
        ST_TK_NX,
        ST_TK_SQ,
        ST_TK_MUL,
        ST_TK_DSTART,
        ST_TK_DWAIT,
        ST_TK_UPD,
        ST_RF_RD,
        ST_RF_DIST,
        ST_RF_R2,
        ST_RF_CMP,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/wpf_ram.sv =====
// ----------------------------------------------------------------------------
// wpf_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wpf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wpf_iter.sv =====
// ----------------------------------------------------------------------------
// wpf_iter: iterative square root and divider
// One shared compare-and-subtract stage, one result bit per cycle.
// ----------------------------------------------------------------------------
module wpf_iter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wpf_pkg::t_iter_ctl        i_ctl,
    input  logic [wpf_pkg::DIST_W-1:0] i_rad,
    input  logic [wpf_pkg::NUM_W-1:0]  i_num,
    input  logic [wpf_pkg::ROOT_W-1:0] i_den,
    output logic [wpf_pkg::NUM_W-1:0]  o_res,
    output logic                      o_done
);
    import wpf_pkg::*;

    localparam int unsigned SH_W  = 2 * ROOT_W;
    localparam int unsigned REM_W = ROOT_W + 3;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic               r_done;
    logic               r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic [SH_W-1:0]    r_sh;
    logic [REM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_q;
    logic [ROOT_W-1:0]  r_den;

    logic [REM_W-1:0]   cur;
    logic [REM_W-1:0]   sub;
    logic               ge;

    always_comb begin
        if (r_root) begin
            cur = {r_rem[REM_W-3:0], r_sh[SH_W-1 -: 2]};
            sub = {1'b0, r_q[ROOT_W-1:0], 2'b01};
        end else begin
            cur = {r_rem[REM_W-2:0], r_sh[SH_W-1]};
            sub = {3'b000, r_den};
        end
        ge = (cur >= sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.root ? CNT_W'(ROOT_W) : CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_root <= i_ctl.root;
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            if (i_ctl.root) begin
                r_sh <= {{(SH_W-DIST_W){1'b0}}, i_rad};
            end else begin
                r_sh <= {i_num, {(SH_W-NUM_W){1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= ge ? (cur - sub) : cur;
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_sh  <= r_root ? {r_sh[SH_W-3:0], 2'b00} : {r_sh[SH_W-2:0], 1'b0};
        end
    end

    assign o_res  = r_q;
    assign o_done = r_done;

endmodule

// ===== rtl/waypoint_follower.sv =====
// ----------------------------------------------------------------------------
// waypoint_follower: one agent following a table of waypoints
// Sequencer around one registered 33x33 multiplier and one iterative
// root/divide unit; the waypoint table sits in two memories.
// ----------------------------------------------------------------------------
// Add, pause, place and unused codes pass through the execute state straight to o_done.
// Set destination visits every stored waypoint in turn; with none it goes straight to done.
// The longest tick is dominated by the root (34 steps) and three divides (51 steps
// each) in the iterative unit, plus a pass over every table entry.
// One request at a time: busy is high from acceptance to the o_done cycle.
// Synchronous reset clears all control state; no clearing pass is needed.
module waypoint_follower #(
    parameter int unsigned MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_action,
    input  logic signed [wpf_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [wpf_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [wpf_pkg::COORD_W-1:0] i_coord_z,
    input  logic [wpf_pkg::RADIUS_W-1:0]       i_wp_radius,
    input  logic [wpf_pkg::DT_W-1:0]           i_delta_time,
    input  logic                               i_pause_flag,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wpf_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [wpf_pkg::CFG_DW-1:0]         i_cfg_data,
    output logic                               o_done,
    output logic signed [wpf_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [wpf_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [wpf_pkg::COORD_W-1:0] o_pos_z,
    output logic signed [wpf_pkg::COORD_W-1:0] o_goal_x,
    output logic signed [wpf_pkg::COORD_W-1:0] o_goal_y,
    output logic signed [wpf_pkg::COORD_W-1:0] o_goal_z,
    output logic                               o_is_moving,
    output logic                               o_table_full
);
    import wpf_pkg::*;

    localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int unsigned SUM_W = NUM_W + 2;

    t_state r_state, n_state;

    logic [2:0]             r_act;
    logic signed [COORD_W-1:0] r_ix, r_iy, r_iz;
    logic [RADIUS_W-1:0]    r_irad;
    logic [DT_W-1:0]        r_dt;
    logic                   r_ipause;

    logic signed [COORD_W-1:0] r_ag [3];
    logic signed [COORD_W-1:0] r_ds [3];
    logic                   r_moving;
    logic                   r_full;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_cyc;
    logic [CW-1:0]          r_idx;
    logic [1:0]             r_k;
    logic [SPEED_W-1:0]     r_speed;
    logic [RADIUS_W-1:0]    r_accr;

    logic [PROD_W-1:0]      r_prod;
    logic [DIST_W-1:0]      r_acc;
    logic [DIST_W-1:0]      r_best;
    logic                   r_found;
    logic signed [COORD_W-1:0] r_bst [3];
    logic [ROOT_W-1:0]      r_len;
    logic [STEP_W-1:0]      r_step;

    logic [MAG_W-1:0]       mul_a, mul_b;
    logic [WP_W-1:0]        wp_rdata, wp_wdata;
    logic                   wp_we;
    logic                   tk_rdata, tk_wdata, tk_we;
    logic [AW-1:0]          tk_waddr;
    logic signed [COORD_W-1:0] wp [3];
    logic [RADIUS_W-1:0]    wp_reach;
    t_iter_ctl              iter_ctl;
    logic [NUM_W-1:0]       iter_res;
    logic                   iter_done;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]       diff_mag;
    logic                   last_idx;
    logic [CW-1:0]          nxt_cyc;
    logic                   wp_zero;
    logic                   dest_zero;
    logic                   cand;
    logic signed [SUM_W-1:0] move_sum;
    logic signed [COORD_W-1:0] move_sat;

    assign wp[0]    = wp_rdata[WP_W-1 -: COORD_W];
    assign wp[1]    = wp_rdata[WP_W-COORD_W-1 -: COORD_W];
    assign wp[2]    = wp_rdata[WP_W-2*COORD_W-1 -: COORD_W];
    assign wp_reach = wp_rdata[RADIUS_W-1:0];

    wpf_ram #(.WIDTH(WP_W), .DEPTH(MAX_WAYPOINTS)) u_wp_ram (
        .i_clk   (i_clk),
        .i_we    (wp_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wp_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (wp_rdata)
    );

    wpf_ram #(.WIDTH(1), .DEPTH(MAX_WAYPOINTS)) u_taken_ram (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (tk_waddr),
        .i_wdata (tk_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (tk_rdata)
    );

    wpf_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (iter_ctl),
        .i_rad   (r_acc),
        .i_num   (r_prod[NUM_W-1:0]),
        .i_den   (r_len),
        .o_res   (iter_res),
        .o_done  (iter_done)
    );

    // Axis difference for the current axis: destination to agent while ticking,
    // agent to the waypoint being read otherwise.
    always_comb begin
        if (r_state == ST_TK_DIST || r_state == ST_TK_MUL || r_state == ST_TK_UPD) begin
            diff = {r_ds[r_k][COORD_W-1], r_ds[r_k]} - {r_ag[r_k][COORD_W-1], r_ag[r_k]};
        end else begin
            diff = {r_ag[r_k][COORD_W-1], r_ag[r_k]} - {wp[r_k][COORD_W-1], wp[r_k]};
        end
        diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    assign last_idx  = (r_idx + CW'(1)) == r_count;
    assign nxt_cyc   = ({{(CW-AW){1'b0}}, r_cyc} + CW'(1) == r_count) ? '0
                       : ({{(CW-AW){1'b0}}, r_cyc} + CW'(1));
    assign wp_zero   = (wp[0] == '0) && (wp[1] == '0) && (wp[2] == '0);
    assign dest_zero = (r_ds[0] == '0) && (r_ds[1] == '0) && (r_ds[2] == '0);
    assign cand      = !tk_rdata && (!r_found || (r_acc < r_best));

    always_comb begin
        if (diff[MAG_W-1]) begin
            move_sum = {{(SUM_W-COORD_W){r_ag[r_k][COORD_W-1]}}, r_ag[r_k]}
                       - {2'b00, iter_res};
        end else begin
            move_sum = {{(SUM_W-COORD_W){r_ag[r_k][COORD_W-1]}}, r_ag[r_k]}
                       + {2'b00, iter_res};
        end
        if (move_sum > SUM_W'(signed'(33'sh0_7FFF_FFFF))) begin
            move_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (move_sum < -SUM_W'(signed'(33'sh0_8000_0000))) begin
            move_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            move_sat = move_sum[COORD_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_act)
                    ACT_DEST: n_state = (r_count == '0) ? ST_DONE : ST_SD_RD;
                    ACT_TICK: n_state = (!r_moving || dest_zero) ? ST_DONE : ST_TK_DIST;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_SD_RD:   n_state = ST_SD_DIST;
            ST_SD_DIST: n_state = (r_k == 2'd3) ? ST_SD_EVAL : ST_SD_DIST;
            ST_SD_EVAL: n_state = last_idx ? ST_SD_FIN : ST_SD_RD;
            ST_SD_FIN:  n_state = ST_DONE;
            ST_TK_DIST: n_state = (r_k == 2'd3) ? ST_TK_ACC : ST_TK_DIST;
            ST_TK_ACC:  n_state = ST_TK_CMP;
            ST_TK_CMP: begin
                if (r_acc <= r_prod) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_TK_NRD;
                end else begin
                    n_state = ST_TK_SQ;
                end
            end
            ST_TK_NRD:  n_state = ST_TK_NX;
            ST_TK_NX:   n_state = ST_RF_RD;
            ST_TK_SQ: begin
                if (iter_done) begin
                    n_state = (iter_res[ROOT_W-1:0] == '0)
                              ? ((r_count == '0) ? ST_DONE : ST_RF_RD) : ST_TK_MUL;
                end
            end
            ST_TK_MUL:    n_state = ST_TK_DSTART;
            ST_TK_DSTART: n_state = ST_TK_DWAIT;
            ST_TK_DWAIT:  n_state = iter_done ? ST_TK_UPD : ST_TK_DWAIT;
            ST_TK_UPD: begin
                if (r_k == 2'd2) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_RF_RD;
                end else begin
                    n_state = ST_TK_MUL;
                end
            end
            ST_RF_RD:   n_state = ST_RF_DIST;
            ST_RF_DIST: n_state = (r_k == 2'd3) ? ST_RF_R2 : ST_RF_DIST;
            ST_RF_R2:   n_state = ST_RF_CMP;
            ST_RF_CMP:  n_state = last_idx ? ST_DONE : ST_RF_RD;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        wp_we         = 1'b0;
        wp_wdata      = {r_ix, r_iy, r_iz, r_irad};
        tk_we         = 1'b0;
        tk_wdata      = 1'b0;
        tk_waddr      = r_idx[AW-1:0];
        iter_ctl      = '0;
        case (r_state)
            ST_EXEC: begin
                if (r_act == ACT_ADD && r_count < CW'(MAX_WAYPOINTS)) begin
                    wp_we    = 1'b1;
                    tk_we    = 1'b1;
                    tk_waddr = r_count[AW-1:0];
                end
            end
            ST_SD_DIST, ST_TK_DIST, ST_RF_DIST: begin
                mul_a = diff_mag;
                mul_b = diff_mag;
            end
            ST_TK_ACC: begin
                mul_a = MAG_W'(r_accr);
                mul_b = MAG_W'(r_accr);
            end
            ST_TK_CMP: begin
                iter_ctl.start = (r_acc > r_prod);
                iter_ctl.root  = 1'b1;
            end
            ST_TK_SQ: begin
                mul_a = MAG_W'(r_speed);
                mul_b = MAG_W'(r_dt);
            end
            ST_TK_MUL: begin
                mul_a = diff_mag;
                mul_b = MAG_W'(r_step);
            end
            ST_TK_DSTART: begin
                iter_ctl.start = 1'b1;
            end
            ST_RF_R2: begin
                mul_a = MAG_W'(wp_reach);
                mul_b = MAG_W'(wp_reach);
            end
            ST_RF_CMP: begin
                tk_we    = 1'b1;
                tk_wdata = (r_acc <= r_prod);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a * mul_b);
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_moving <= 1'b0;
            r_full   <= 1'b0;
            r_count  <= '0;
            r_cyc    <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_speed  <= SPEED_RESET;
            r_accr   <= ACCEPT_RESET;
            r_found  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ag[i] <= '0;
                r_ds[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SPEED) begin
                    r_speed <= (i_cfg_data[SPEED_W-1:0] > SPEED_CAP)
                               ? SPEED_CAP : i_cfg_data[SPEED_W-1:0];
                end else if (i_cfg_index == CFG_ACCEPT) begin
                    r_accr <= i_cfg_data[RADIUS_W-1:0];
                end
            end
            case (r_state)
                ST_IDLE: begin
                    r_full  <= 1'b0;
                    r_idx   <= '0;
                    r_k     <= '0;
                    r_found <= 1'b0;
                end
                ST_EXEC: begin
                    case (r_act)
                        ACT_ADD: begin
                            if (r_count < CW'(MAX_WAYPOINTS)) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                        ACT_DEST: begin
                            r_ds[0]  <= r_ix;
                            r_ds[1]  <= r_iy;
                            r_ds[2]  <= r_iz;
                            r_moving <= 1'b1;
                        end
                        ACT_PAUSE: r_moving <= !r_ipause;
                        ACT_PLACE: begin
                            r_ag[0] <= r_ix;
                            r_ag[1] <= r_iy;
                            r_ag[2] <= r_iz;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SD_DIST, ST_TK_DIST, ST_RF_DIST: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd1) begin
                        r_acc <= r_prod;
                    end else if (r_k != 2'd0) begin
                        r_acc <= r_acc + r_prod;
                    end
                end
                ST_SD_EVAL: begin
                    r_k <= '0;
                    if (cand) begin
                        r_found <= 1'b1;
                        r_best  <= r_acc;
                        r_bst   <= wp;
                    end
                    if (!last_idx) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_SD_FIN: begin
                    if (r_found && !((r_bst[0] == '0) && (r_bst[1] == '0)
                                     && (r_bst[2] == '0))) begin
                        r_ds <= r_bst;
                    end
                end
                ST_TK_CMP: begin
                    r_k <= '0;
                    if (r_acc <= r_prod) begin
                        if (r_count == '0) begin
                            r_moving <= 1'b0;
                        end else begin
                            r_cyc <= nxt_cyc[AW-1:0];
                            r_idx <= nxt_cyc;
                        end
                    end
                end
                ST_TK_NX: begin
                    if (wp_zero) begin
                        r_moving <= 1'b0;
                    end else begin
                        r_ds <= wp;
                    end
                    r_idx <= '0;
                end
                ST_TK_SQ: begin
                    r_len  <= iter_res[ROOT_W-1:0];
                    r_step <= r_prod[STEP_W+7:8];
                end
                ST_TK_UPD: begin
                    r_ag[r_k] <= move_sat;
                    r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
                ST_RF_CMP: begin
                    r_k   <= '0;
                    r_idx <= r_idx + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_act    <= i_action;
            r_ix     <= i_coord_x;
            r_iy     <= i_coord_y;
            r_iz     <= i_coord_z;
            r_irad   <= i_wp_radius;
            r_dt     <= i_delta_time;
            r_ipause <= i_pause_flag;
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_cfg_ready  = !busy;
    assign o_done       = (r_state == ST_DONE);
    assign o_pos_x      = r_ag[0];
    assign o_pos_y      = r_ag[1];
    assign o_pos_z      = r_ag[2];
    assign o_goal_x     = r_ds[0];
    assign o_goal_y     = r_ds[1];
    assign o_goal_z     = r_ds[2];
    assign o_is_moving  = r_moving;
    assign o_table_full = r_full;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WAYPOINTS))
        else $error("waypoint count beyond table size");

    a_cyc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ({{(CW-AW){1'b0}}, r_cyc} < r_count))
        else $error("cycle index outside the table");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after a result");

    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> (r_act == ACT_ADD && r_count == CW'(MAX_WAYPOINTS)))
        else $error("table full reported for a request that was not a refused add");

endmodule

// ===== tb/waypoint_follower_tb.sv =====
// ----------------------------------------------------------------------------
// waypoint_follower_tb: self-checking testbench of the waypoint follower
// Drives add, destination, tick, pause and place requests with directed
// corner cases and random traffic under several idle patterns. A predictor
// in the bench computes each expected result, and a checker compares it,
// field by field, with every strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waypoint_follower_tb;
    import wpf_pkg::*;

    localparam int unsigned NWP = MAX_WAYPOINTS_DEF;
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [2:0]           action;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   cz;
        logic [RADIUS_W-1:0]  radius;
        logic [DT_W-1:0]      dt;
        logic                 pause;
    } t_request;

    typedef struct {
        logic [COORD_W-1:0] px, py, pz, gx, gy, gz;
        logic               moving;
        logic               full;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_action = '0;
    logic signed [COORD_W-1:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [RADIUS_W-1:0] i_wp_radius = '0;
    logic [DT_W-1:0] i_delta_time = '0;
    logic i_pause_flag = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic o_done;
    logic signed [COORD_W-1:0] o_pos_x, o_pos_y, o_pos_z, o_goal_x, o_goal_y, o_goal_z;
    logic o_is_moving, o_table_full;

    waypoint_follower dut (.*);

    always #2 i_clk = ~i_clk;

    // Bench copy of the block state.
    longint wp_x[NWP], wp_y[NWP], wp_z[NWP];
    longint unsigned wp_reach[NWP];
    bit wp_taken[NWP];
    int unsigned wp_count, cyc_idx;
    longint goal_x, goal_y, goal_z, agent_x, agent_y, agent_z;
    bit moving;
    longint unsigned speed, accept_r;

    t_status pending_status[$];
    int unsigned mismatches = 0;
    int unsigned idle_pct = 0;

    function automatic logic [67:0] sq_dist(longint ax, longint ay, longint az,
                                            longint bx, longint by, longint bz);
        longint dx, dy, dz;
        dx = ax - bx; if (dx < 0) dx = -dx;
        dy = ay - by; if (dy < 0) dy = -dy;
        dz = az - bz; if (dz < 0) dz = -dz;
        return 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
    endfunction

    function automatic longint unsigned int_sqrt(logic [67:0] x);
        logic [34:0] r, c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (35'd1 << b);
            if (70'(c) * 70'(c) <= 70'(x)) r = c;
        end
        return longint'(r);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint axis_step(longint d, longint unsigned st, longint unsigned len);
        longint unsigned m;
        m = ((d < 0 ? -d : d) * st) / len;
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic void mark_occupancy();
        for (int i = 0; i < wp_count; i++)
            wp_taken[i] = sq_dist(agent_x, agent_y, agent_z, wp_x[i], wp_y[i], wp_z[i])
                          <= 68'(wp_reach[i] * wp_reach[i]);
    endfunction

    function automatic void advance_agent(longint unsigned dt);
        logic [67:0] d2;
        longint unsigned len, st;
        int unsigned n;
        longint dx, dy, dz;
        if (!moving || (goal_x == 0 && goal_y == 0 && goal_z == 0)) return;
        d2 = sq_dist(goal_x, goal_y, goal_z, agent_x, agent_y, agent_z);
        if (d2 <= 68'(accept_r * accept_r)) begin
            if (wp_count == 0) begin
                moving = 0;
            end else begin
                n = (cyc_idx + 1) % wp_count;
                cyc_idx = n;
                if (wp_x[n] == 0 && wp_y[n] == 0 && wp_z[n] == 0) begin
                    moving = 0;
                end else begin
                    goal_x = wp_x[n]; goal_y = wp_y[n]; goal_z = wp_z[n];
                end
            end
        end else begin
            len = int_sqrt(d2);
            st = (speed * dt) >> 8;
            if (len != 0) begin
                dx = goal_x - agent_x; dy = goal_y - agent_y; dz = goal_z - agent_z;
                agent_x = clamp32(agent_x + axis_step(dx, st, len));
                agent_y = clamp32(agent_y + axis_step(dy, st, len));
                agent_z = clamp32(agent_z + axis_step(dz, st, len));
            end
        end
        mark_occupancy();
    endfunction

    function automatic void pick_nearest(longint x, longint y, longint z);
        int best;
        logic [67:0] bd, d;
        best = -1; bd = '0;
        goal_x = x; goal_y = y; goal_z = z;
        moving = 1;
        for (int i = 0; i < wp_count; i++) begin
            if (!wp_taken[i]) begin
                d = sq_dist(agent_x, agent_y, agent_z, wp_x[i], wp_y[i], wp_z[i]);
                // Strict compare: the first of equally near entries wins.
                if (best < 0 || d < bd) begin
                    best = i; bd = d;
                end
            end
        end
        if (best >= 0 && !(wp_x[best] == 0 && wp_y[best] == 0 && wp_z[best] == 0)) begin
            goal_x = wp_x[best]; goal_y = wp_y[best]; goal_z = wp_z[best];
        end
    endfunction

    function automatic t_status predict_status(t_request rq);
        t_status s;
        longint x, y, z;
        x = longint'(signed'(rq.cx)); y = longint'(signed'(rq.cy));
        z = longint'(signed'(rq.cz));
        s.full = 0;
        case (rq.action)
            ACT_ADD: begin
                if (wp_count >= NWP) begin
                    s.full = 1;
                end else begin
                    wp_x[wp_count] = x; wp_y[wp_count] = y; wp_z[wp_count] = z;
                    wp_reach[wp_count] = rq.radius;
                    wp_taken[wp_count] = 0;
                    wp_count++;
                end
            end
            ACT_DEST:  pick_nearest(x, y, z);
            ACT_TICK:  advance_agent(rq.dt);
            ACT_PAUSE: moving = !rq.pause;
            ACT_PLACE: begin
                agent_x = x; agent_y = y; agent_z = z;
            end
            default: ;
        endcase
        s.px = agent_x[31:0]; s.py = agent_y[31:0]; s.pz = agent_z[31:0];
        s.gx = goal_x[31:0]; s.gy = goal_y[31:0]; s.gz = goal_z[31:0];
        s.moving = moving;
        return s;
    endfunction

    // Sends one request; start is only lowered at an edge where the block is busy.
    task automatic send_request(t_request rq);
        while ($urandom_range(99, 0) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        while (busy) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_action = rq.action;
        i_coord_x = rq.cx; i_coord_y = rq.cy; i_coord_z = rq.cz;
        i_wp_radius = rq.radius; i_delta_time = rq.dt; i_pause_flag = rq.pause;
        start = 1'b1;
        pending_status.push_back(predict_status(rq));
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (busy || pending_status.size() != 0) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DW-1:0] data);
        drain();
        i_cfg_valid = 1'b1; i_cfg_index = idx; i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SPEED)
            speed = (data[SPEED_W-1:0] > SPEED_CAP) ? SPEED_CAP : data[SPEED_W-1:0];
        else if (idx == CFG_ACCEPT)
            accept_r = data[RADIUS_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_request make_req(logic [2:0] a, longint x, longint y, longint z,
                                          logic [RADIUS_W-1:0] r, logic [DT_W-1:0] dt,
                                          logic p);
        t_request rq;
        rq.action = a; rq.cx = x[31:0]; rq.cy = y[31:0]; rq.cz = z[31:0];
        rq.radius = r; rq.dt = dt; rq.pause = p;
        return rq;
    endfunction

    function automatic longint rand_coord();
        int unsigned k;
        k = $urandom_range(99, 0);
        if (k < 5) return 0;
        if (k < 15) return longint'(signed'($urandom()));
        return longint'($urandom_range(120000, 0)) - 60000;
    endfunction

    function automatic t_request rand_req();
        t_request rq;
        int unsigned k;
        rq = make_req(ACT_TICK, rand_coord(), rand_coord(), rand_coord(),
                      RADIUS_W'(($urandom_range(3, 0) == 0) ? $urandom()
                                                             : $urandom_range(20000, 0)),
                      ($urandom_range(7, 0) == 0) ? 16'hFFFF : DT_W'($urandom()),
                      $urandom_range(3, 0) == 0);
        k = $urandom_range(99, 0);
        if (k < 8)       rq.action = ACT_ADD;
        else if (k < 26) rq.action = ACT_DEST;
        else if (k < 80) rq.action = ACT_TICK;
        else if (k < 88) rq.action = ACT_PAUSE;
        else if (k < 97) rq.action = ACT_PLACE;
        else             rq.action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        return rq;
    endfunction

    always @(posedge i_clk) begin
        t_status e;
        if (i_rst_n && o_done) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result at %0t", $realtime);
            end else begin
                e = pending_status.pop_front();
                if (o_pos_x !== e.px || o_pos_y !== e.py || o_pos_z !== e.pz ||
                    o_goal_x !== e.gx || o_goal_y !== e.gy || o_goal_z !== e.gz ||
                    o_is_moving !== e.moving || o_table_full !== e.full) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch at %0t: exp pos %h %h %h goal %h %h %h",
                                  " mv %b full %b, got pos %h %h %h goal %h %h %h",
                                  " mv %b full %b"},
                                 $realtime, e.px, e.py, e.pz, e.gx, e.gy, e.gz,
                                 e.moving, e.full, o_pos_x, o_pos_y, o_pos_z,
                                 o_goal_x, o_goal_y, o_goal_z, o_is_moving,
                                 o_table_full);
                end
            end
        end
    end

    // Unused codes, placement at the extremes and a tick with no destination.
    task automatic test_idle_requests();
        send_request(make_req(ACT_SPARE_FIRST, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_SPARE_LAST, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0));
        send_request(make_req(ACT_PLACE, 64'sd2147483647, -64'sd2147483648, -1, 0, 0, 0));
        send_request(make_req(ACT_PLACE, -64'sd2147483648, 64'sd2147483647, 0, 0, 0, 0));
        send_request(make_req(ACT_PLACE, 0, 0, 0, 0, 0, 0));
    endtask

    // Destination with an empty table, then a table with a waypoint at the origin.
    task automatic test_destination();
        send_request(make_req(ACT_DEST, 25600, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0));
        send_request(make_req(ACT_ADD, 0, 0, 0, 24'hFFFFFF, 0, 0));
        send_request(make_req(ACT_ADD, 51200, 0, 0, 2560, 0, 0));
        send_request(make_req(ACT_ADD, 51200, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_ADD, -40000, 30000, 9000, 5000, 0, 0));
        send_request(make_req(ACT_DEST, 1000, 1000, 1000, 0, 0, 0));
    endtask

    // Steps toward a far goal, arrivals that cycle the table, and pause/resume.
    task automatic test_motion();
        send_request(make_req(ACT_PLACE, 60000, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_DEST, 1, 1, 1, 0, 0, 0));
        send_request(make_req(ACT_PAUSE, 0, 0, 0, 0, 0, 1));
        send_request(make_req(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0));
        send_request(make_req(ACT_PAUSE, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            send_request(make_req(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0));
        send_request(make_req(ACT_TICK, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int unsigned n, int unsigned pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            t_request rq;
            rq = rand_req();
            // Keep room in the table for the refusal test at the end.
            if (rq.action == ACT_ADD && wp_count >= NWP - 4) rq.action = ACT_TICK;
            send_request(rq);
        end
        idle_pct = 0;
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_SPEED, 24'd1000);
        write_reg(CFG_ACCEPT, 24'd0);
        test_random(200, 0);
        write_reg(CFG_SPEED, 24'hFFFFFF);
        write_reg(CFG_ACCEPT, 24'hFFFFFF);
        test_random(150, 47);
        write_reg(CFG_SPEED, 24'd0);
        write_reg(CFG_ACCEPT, 24'd25600);
        test_random(150, 10);
        write_reg(CFG_SPEED, CFG_DW'($urandom()));
        write_reg(CFG_ACCEPT, CFG_DW'($urandom_range(30000, 0)));
        test_random(250, 47);
        write_reg(CFG_SPEED, CFG_DW'(SPEED_RESET));
        write_reg(CFG_ACCEPT, CFG_DW'(ACCEPT_RESET));
        test_random(200, 0);
    endtask

    task automatic test_table_full();
        while (wp_count < NWP)
            send_request(make_req(ACT_ADD, rand_coord(), rand_coord(), rand_coord(),
                                  RADIUS_W'($urandom_range(20000, 0)), 0, 0));
        send_request(make_req(ACT_ADD, 1, 2, 3, 4, 0, 0));
        send_request(make_req(ACT_ADD, 5, 6, 7, 8, 0, 0));
        send_request(make_req(ACT_DEST, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            send_request(make_req(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0));
    endtask

    initial begin
        wp_count = 0; cyc_idx = 0; moving = 0;
        goal_x = 0; goal_y = 0; goal_z = 0; agent_x = 0; agent_y = 0; agent_z = 0;
        speed = SPEED_RESET; accept_r = ACCEPT_RESET;
        for (int i = 0; i < NWP; i++) wp_taken[i] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_idle_requests();
        test_destination();
        test_motion();
        test_config_sweep();
        test_table_full();
        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wpf_pkg.sv
rtl/wpf_ram.sv
rtl/wpf_iter.sv
rtl/waypoint_follower.sv
tb/waypoint_follower_tb.sv
